// ----- rtl/sbpt_pkg.sv -----
// ----------------------------------------------------------------------------
// sbpt_pkg
// Shared types and constants of the servo bus packet transaction block.
// ----------------------------------------------------------------------------
package sbpt_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CntW       = 6;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned KindW      = 2;
  localparam int unsigned MaxParams  = 32;
  localparam int unsigned MaxReply   = 32;
  localparam int unsigned MaxResults = 6;
  localparam int unsigned ResCntW    = $clog2(MaxResults + 1);

  localparam logic [ByteW-1:0] SyncByte = 8'hFF;
  localparam logic [ByteW-1:0] LenExtra = 8'd2;

  typedef enum logic [CmdW-1:0] {
    CmdStart   = 2'd0,
    CmdParam   = 2'd1,
    CmdReply   = 2'd2,
    CmdTimeout = 2'd3
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KindTx   = 2'd0,
    KindData = 2'd1,
    KindDone = 2'd2
  } kind_e;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [ByteW-1:0] servo_id;
    logic [ByteW-1:0] instruction;
    logic [CntW-1:0]  param_count;
    logic [CntW-1:0]  reply_data_count;
    logic [ByteW-1:0] data_byte;
  } item_t;

  // All results caused by one input item; only the byte differs between them.
  typedef struct packed {
    logic [ResCntW-1:0]                cnt;
    kind_e                             kind;
    logic [MaxResults-1:0][ByteW-1:0]  bytes;
    logic                              header_bad;
    logic                              id_bad;
    logic                              checksum_bad;
    logic                              timed_out;
    logic [ByteW-1:0]                  servo_error;
  } bundle_t;

endpackage

// ----- rtl/sbpt_if.sv -----
// ----------------------------------------------------------------------------
// sbpt_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface sbpt_in_if;
  import sbpt_pkg::*;

  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [ByteW-1:0] servo_id;
  logic [ByteW-1:0] instruction;
  logic [CntW-1:0]  param_count;
  logic [CntW-1:0]  reply_data_count;
  logic [ByteW-1:0] data_byte;

  modport source (
    output valid, command, servo_id, instruction, param_count, reply_data_count, data_byte,
    input  ready
  );
  modport sink (
    input  valid, command, servo_id, instruction, param_count, reply_data_count, data_byte,
    output ready
  );
endinterface

interface sbpt_out_if;
  import sbpt_pkg::*;

  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [ByteW-1:0] out_byte;
  logic             header_bad;
  logic             id_bad;
  logic             checksum_bad;
  logic             timed_out;
  logic [ByteW-1:0] servo_error;
  logic             last;

  modport source (
    output valid, kind, out_byte, header_bad, id_bad, checksum_bad, timed_out,
           servo_error, last,
    input  ready
  );
  modport sink (
    input  valid, kind, out_byte, header_bad, id_bad, checksum_bad, timed_out,
           servo_error, last,
    output ready
  );
endinterface

// ----- rtl/servo_bus_packet_transaction.sv -----
// ----------------------------------------------------------------------------
// servo_bus_packet_transaction
// Builds a servo bus request packet and checks the status reply.
// ----------------------------------------------------------------------------
// An item waits in the input register until the result register takes it.
// Throughput: one item per cycle while no item gives two results and the
// output is ready; a start item gives five or six results, one per transfer.
// Reset clears the transaction state to idle and empties both registers.
module servo_bus_packet_transaction (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbpt_in_if.sink    cmd_i,
  sbpt_out_if.source res_o
);
  import sbpt_pkg::*;

  item_t   item;
  bundle_t bundle;
  logic    load;

  assign item.command          = cmd_i.command;
  assign item.servo_id         = cmd_i.servo_id;
  assign item.instruction      = cmd_i.instruction;
  assign item.param_count      = cmd_i.param_count;
  assign item.reply_data_count = cmd_i.reply_data_count;
  assign item.data_byte        = cmd_i.data_byte;

  sbpt_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .in_item_i  (item),
    .load_i     (load),
    .bundle_o   (bundle)
  );

  sbpt_serializer u_ser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .bundle_i (bundle),
    .load_o   (load),
    .res_o    (res_o)
  );

  // A done result always closes the results of its item.
  a_done_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.kind == KindDone) |-> res_o.last)
    else $error("done result not marked last");

  // A timeout carries no reply status.
  a_timeout_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.timed_out |->
      !res_o.header_bad && !res_o.id_bad && !res_o.checksum_bad &&
      (res_o.servo_error == '0))
    else $error("timeout result carries reply flags");

  // Transmit bytes never carry reply status.
  a_tx_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.kind == KindTx) |->
      !res_o.timed_out && !res_o.checksum_bad && (res_o.servo_error == '0))
    else $error("transmit byte carries status");

  // A stalled result keeps its byte and kind until it is taken.
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> res_o.valid && $stable(res_o.out_byte) &&
      $stable(res_o.kind))
    else $error("stalled result changed");

endmodule

// ----- rtl/sbpt_core.sv -----
// ----------------------------------------------------------------------------
// sbpt_core
// Input register and transaction state; turns one item into a result bundle.
// ----------------------------------------------------------------------------
module sbpt_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sbpt_pkg::item_t  in_item_i,
  input  logic             load_i,
  output sbpt_pkg::bundle_t bundle_o
);
  import sbpt_pkg::*;

  typedef enum logic [4:0] {
    PhIdle   = 5'b00001,
    PhParams = 5'b00010,
    PhHead   = 5'b00100,
    PhData   = 5'b01000,
    PhSum    = 5'b10000
  } phase_e;

  localparam logic [CntW-1:0] MaxParamsC = CntW'(MaxParams);
  localparam logic [CntW-1:0] MaxReplyC  = CntW'(MaxReply);

  logic             item_valid_q;
  item_t            item_q;
  logic             fire;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] exp_id_q, exp_id_d;
  logic [ByteW-1:0] req_sum_q, req_sum_d;
  logic [CntW-1:0]  params_left_q, params_left_d;
  logic [CntW-1:0]  reply_len_q, reply_len_d;
  logic [CntW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] reply_sum_q, reply_sum_d;
  logic             hdr_bad_q, hdr_bad_d;
  logic             id_bad_q, id_bad_d;
  logic [ByteW-1:0] err_q, err_d;

  logic [CntW-1:0]  pc_sat;
  logic [CntW-1:0]  rc_sat;
  logic [ByteW-1:0] len;
  logic [ByteW-1:0] start_sum;
  logic [ByteW-1:0] param_sum;
  logic [CntW-1:0]  left_next;
  logic [CntW-1:0]  pos_next;
  logic [ByteW-1:0] rsum_next;
  bundle_t          bundle;

  assign fire       = item_valid_q && load_i;
  assign in_ready_o = !item_valid_q || load_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign pc_sat    = (item_q.param_count > MaxParamsC) ? MaxParamsC : item_q.param_count;
  assign rc_sat    = (item_q.reply_data_count > MaxReplyC) ? MaxReplyC
                                                           : item_q.reply_data_count;
  assign len       = ByteW'(pc_sat) + LenExtra;
  assign start_sum = item_q.servo_id + len + item_q.instruction;
  assign param_sum = req_sum_q + item_q.data_byte;
  assign left_next = (params_left_q != '0) ? params_left_q - CntW'(1) : '0;
  assign pos_next  = pos_q + CntW'(1);
  assign rsum_next = reply_sum_q + item_q.data_byte;

  always_comb begin
    phase_d       = phase_q;
    exp_id_d      = exp_id_q;
    req_sum_d     = req_sum_q;
    params_left_d = params_left_q;
    reply_len_d   = reply_len_q;
    pos_d         = pos_q;
    reply_sum_d   = reply_sum_q;
    hdr_bad_d     = hdr_bad_q;
    id_bad_d      = id_bad_q;
    err_d         = err_q;

    bundle              = '0;
    bundle.kind         = KindTx;

    case (cmd_e'(item_q.command))
      CmdStart: begin
        exp_id_d      = item_q.servo_id;
        reply_len_d   = rc_sat;
        params_left_d = pc_sat;
        req_sum_d     = start_sum;
        hdr_bad_d     = 1'b0;
        id_bad_d      = 1'b0;
        err_d         = '0;
        bundle.bytes[0] = SyncByte;
        bundle.bytes[1] = SyncByte;
        bundle.bytes[2] = item_q.servo_id;
        bundle.bytes[3] = len;
        bundle.bytes[4] = item_q.instruction;
        bundle.cnt      = ResCntW'(5);
        if (pc_sat == '0) begin
          // Empty parameter list: the checksum closes the request at once.
          bundle.bytes[5] = ~start_sum;
          bundle.cnt      = ResCntW'(6);
          phase_d         = PhHead;
          pos_d           = '0;
          reply_sum_d     = '0;
        end else begin
          phase_d = PhParams;
        end
      end
      CmdParam: begin
        if (phase_q == PhParams) begin
          bundle.bytes[0] = item_q.data_byte;
          bundle.cnt      = ResCntW'(1);
          req_sum_d       = param_sum;
          params_left_d   = left_next;
          if (left_next == '0) begin
            bundle.bytes[1] = ~param_sum;
            bundle.cnt      = ResCntW'(2);
            phase_d         = PhHead;
            pos_d           = '0;
            reply_sum_d     = '0;
            hdr_bad_d       = 1'b0;
            id_bad_d        = 1'b0;
            err_d           = '0;
          end
        end
      end
      CmdReply: begin
        case (phase_q)
          PhHead: begin
            if (pos_q < CntW'(2)) begin
              if (item_q.data_byte != SyncByte) hdr_bad_d = 1'b1;
              pos_d = pos_next;
            end else if (pos_q == CntW'(2)) begin
              if (item_q.data_byte != exp_id_q) id_bad_d = 1'b1;
              reply_sum_d = rsum_next;
              pos_d       = pos_next;
            end else if (pos_q == CntW'(3)) begin
              // Length byte enters the checksum but is not checked.
              reply_sum_d = rsum_next;
              pos_d       = pos_next;
            end else begin
              err_d       = item_q.data_byte;
              reply_sum_d = rsum_next;
              pos_d       = '0;
              phase_d     = (reply_len_q != '0) ? PhData : PhSum;
            end
          end
          PhData: begin
            bundle.cnt         = ResCntW'(1);
            bundle.kind        = KindData;
            bundle.bytes[0]    = item_q.data_byte;
            bundle.servo_error = err_q;
            reply_sum_d        = rsum_next;
            pos_d              = pos_next;
            if (pos_next >= reply_len_q) phase_d = PhSum;
          end
          PhSum: begin
            bundle.cnt          = ResCntW'(1);
            bundle.kind         = KindDone;
            bundle.header_bad   = hdr_bad_q;
            bundle.id_bad       = id_bad_q;
            bundle.checksum_bad = (item_q.data_byte != ~reply_sum_q);
            bundle.servo_error  = err_q;
            phase_d             = PhIdle;
            pos_d               = '0;
          end
          default: begin
          end
        endcase
      end
      CmdTimeout: begin
        if (phase_q != PhIdle) begin
          bundle.cnt       = ResCntW'(1);
          bundle.kind      = KindDone;
          bundle.timed_out = 1'b1;
          phase_d          = PhIdle;
          pos_d            = '0;
          params_left_d    = '0;
        end
      end
      default: begin
      end
    endcase

    if (!item_valid_q) bundle.cnt = '0;
  end

  assign bundle_o = bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhIdle;
      exp_id_q      <= '0;
      req_sum_q     <= '0;
      params_left_q <= '0;
      reply_len_q   <= '0;
      pos_q         <= '0;
      reply_sum_q   <= '0;
      hdr_bad_q     <= 1'b0;
      id_bad_q      <= 1'b0;
      err_q         <= '0;
    end else if (fire) begin
      phase_q       <= phase_d;
      exp_id_q      <= exp_id_d;
      req_sum_q     <= req_sum_d;
      params_left_q <= params_left_d;
      reply_len_q   <= reply_len_d;
      pos_q         <= pos_d;
      reply_sum_q   <= reply_sum_d;
      hdr_bad_q     <= hdr_bad_d;
      id_bad_q      <= id_bad_d;
      err_q         <= err_d;
    end
  end

endmodule

// ----- rtl/sbpt_serializer.sv -----
// ----------------------------------------------------------------------------
// sbpt_serializer
// Result register that hands out the bytes of one bundle, one per transfer.
// ----------------------------------------------------------------------------
module sbpt_serializer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbpt_pkg::bundle_t bundle_i,
  output logic              load_o,
  sbpt_out_if.source        res_o
);
  import sbpt_pkg::*;

  logic [ResCntW-1:0]               cnt_q;
  logic [MaxResults-1:0][ByteW-1:0] bytes_q;
  kind_e                            kind_q;
  logic                             hdr_bad_q;
  logic                             id_bad_q;
  logic                             csum_bad_q;
  logic                             timed_out_q;
  logic [ByteW-1:0]                 err_q;
  logic                             xfer;
  logic                             is_last;

  assign is_last = (cnt_q == ResCntW'(1));
  assign xfer    = res_o.valid && res_o.ready;
  // A new bundle enters once the register is empty or its final result leaves.
  assign load_o  = (cnt_q == '0) || (xfer && is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_o) begin
      cnt_q <= bundle_i.cnt;
    end else if (xfer) begin
      cnt_q <= cnt_q - ResCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      bytes_q     <= bundle_i.bytes;
      kind_q      <= bundle_i.kind;
      hdr_bad_q   <= bundle_i.header_bad;
      id_bad_q    <= bundle_i.id_bad;
      csum_bad_q  <= bundle_i.checksum_bad;
      timed_out_q <= bundle_i.timed_out;
      err_q       <= bundle_i.servo_error;
    end else if (xfer) begin
      bytes_q <= {ByteW'(0), bytes_q[MaxResults-1:1]};
    end
  end

  assign res_o.valid        = (cnt_q != '0);
  assign res_o.kind         = kind_q;
  assign res_o.out_byte     = bytes_q[0];
  assign res_o.header_bad   = hdr_bad_q;
  assign res_o.id_bad       = id_bad_q;
  assign res_o.checksum_bad = csum_bad_q;
  assign res_o.timed_out    = timed_out_q;
  assign res_o.servo_error  = err_q;
  assign res_o.last         = is_last;

endmodule

// ----- sim/tb_servo_bus_packet_transaction.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_servo_bus_packet_transaction
// Drives request and reply traffic into the servo bus transaction block and
// checks every result against a cycle-free predictor of the packet protocol.
// ----------------------------------------------------------------------------
module tb_servo_bus_packet_transaction;
  import sbpt_pkg::*;

  typedef enum logic [2:0] {
    PhIdle,
    PhParams,
    PhHead,
    PhData,
    PhSum
  } bus_phase_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] out_byte;
    logic             header_bad;
    logic             id_bad;
    logic             checksum_bad;
    logic             timed_out;
    logic [ByteW-1:0] servo_error;
    logic             last;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sbpt_in_if  cmd_if ();
  sbpt_out_if res_if ();

  servo_bus_packet_transaction dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  always #1 clk_i = ~clk_i;

  item_t   pending_items[$];
  result_t expected_results[$];

  int items_total    = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int errors         = 0;

  // Predictor state of the transaction.
  bus_phase_e       bus_phase   = PhIdle;
  logic [ByteW-1:0] req_id      = '0;
  logic [ByteW-1:0] req_sum     = '0;
  logic [CntW-1:0]  params_due  = '0;
  logic [CntW-1:0]  reply_total = '0;
  logic [CntW-1:0]  reply_idx   = '0;
  logic [ByteW-1:0] reply_acc   = '0;
  logic             hdr_bad     = 1'b0;
  logic             id_mismatch = 1'b0;
  logic [ByteW-1:0] err_held    = '0;

  function automatic result_t mk_result(kind_e k, logic [ByteW-1:0] b, logic hb, logic ib,
                                        logic cb, logic to, logic [ByteW-1:0] err);
    result_t r;
    r.kind         = k;
    r.out_byte     = b;
    r.header_bad   = hb;
    r.id_bad       = ib;
    r.checksum_bad = cb;
    r.timed_out    = to;
    r.servo_error  = err;
    r.last         = 1'b0;
    return r;
  endfunction

  task automatic start_reply();
    bus_phase   = PhHead;
    reply_idx   = '0;
    reply_acc   = '0;
    hdr_bad     = 1'b0;
    id_mismatch = 1'b0;
    err_held    = '0;
  endtask

  task automatic predict_results(item_t it);
    result_t          batch[$];
    logic [CntW-1:0]  pc;
    logic [CntW-1:0]  rc;
    logic [ByteW-1:0] len_b;
    logic             cb;
    case (cmd_e'(it.command))
      CmdStart: begin
        pc = (it.param_count > MaxParams) ? CntW'(MaxParams) : it.param_count;
        rc = (it.reply_data_count > MaxReply) ? CntW'(MaxReply) : it.reply_data_count;
        len_b       = ByteW'(pc) + LenExtra;
        req_id      = it.servo_id;
        reply_total = rc;
        params_due  = pc;
        req_sum     = it.servo_id + len_b + it.instruction;
        hdr_bad     = 1'b0;
        id_mismatch = 1'b0;
        err_held    = '0;
        batch.push_back(mk_result(KindTx, SyncByte, 0, 0, 0, 0, '0));
        batch.push_back(mk_result(KindTx, SyncByte, 0, 0, 0, 0, '0));
        batch.push_back(mk_result(KindTx, it.servo_id, 0, 0, 0, 0, '0));
        batch.push_back(mk_result(KindTx, len_b, 0, 0, 0, 0, '0));
        batch.push_back(mk_result(KindTx, it.instruction, 0, 0, 0, 0, '0));
        if (pc == 0) begin
          batch.push_back(mk_result(KindTx, ~req_sum, 0, 0, 0, 0, '0));
          start_reply();
        end else begin
          bus_phase = PhParams;
        end
      end
      CmdParam: begin
        if (bus_phase == PhParams) begin
          batch.push_back(mk_result(KindTx, it.data_byte, 0, 0, 0, 0, '0));
          req_sum = req_sum + it.data_byte;
          if (params_due != 0) params_due = params_due - 1'b1;
          if (params_due == 0) begin
            batch.push_back(mk_result(KindTx, ~req_sum, 0, 0, 0, 0, '0));
            start_reply();
          end
        end
      end
      CmdReply: begin
        case (bus_phase)
          PhHead: begin
            if (reply_idx < 2) begin
              if (it.data_byte != SyncByte) hdr_bad = 1'b1;
            end else if (reply_idx == 2) begin
              if (it.data_byte != req_id) id_mismatch = 1'b1;
            end else if (reply_idx == 4) begin
              err_held = it.data_byte;
            end
            if (reply_idx >= 2) reply_acc = reply_acc + it.data_byte;
            if (reply_idx == 4) begin
              reply_idx = '0;
              bus_phase = (reply_total != 0) ? PhData : PhSum;
            end else begin
              reply_idx = reply_idx + 1'b1;
            end
          end
          PhData: begin
            batch.push_back(mk_result(KindData, it.data_byte, 0, 0, 0, 0, err_held));
            reply_acc = reply_acc + it.data_byte;
            reply_idx = reply_idx + 1'b1;
            if (reply_idx >= reply_total) bus_phase = PhSum;
          end
          PhSum: begin
            cb = (it.data_byte != ~reply_acc);
            batch.push_back(mk_result(KindDone, '0, hdr_bad, id_mismatch, cb, 0, err_held));
            bus_phase = PhIdle;
            reply_idx = '0;
          end
          default: ;
        endcase
      end
      default: begin
        if (bus_phase != PhIdle) begin
          batch.push_back(mk_result(KindDone, '0, 0, 0, 0, 1, '0));
          bus_phase  = PhIdle;
          reply_idx  = '0;
          params_due = '0;
        end
      end
    endcase
    if (batch.size() != 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) expected_results.push_back(batch[i]);
  endtask

  // Mostly short gaps, a few long ones, and now and then a burst with none.
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst = $urandom_range(10, 30);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Driver: offers pending items and feeds each transfer to the predictor.
  int tx_gap   = 0;
  int tx_burst = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    item_t cur;
    if (!rst_ni) begin
      cmd_if.valid            <= 1'b0;
      cmd_if.command          <= '0;
      cmd_if.servo_id         <= '0;
      cmd_if.instruction      <= '0;
      cmd_if.param_count      <= '0;
      cmd_if.reply_data_count <= '0;
      cmd_if.data_byte        <= '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        cur.command          = cmd_if.command;
        cur.servo_id         = cmd_if.servo_id;
        cur.instruction      = cmd_if.instruction;
        cur.param_count      = cmd_if.param_count;
        cur.reply_data_count = cmd_if.reply_data_count;
        cur.data_byte        = cmd_if.data_byte;
        predict_results(cur);
        items_accepted++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          cmd_if.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur = pending_items.pop_front();
          cmd_if.valid            <= 1'b1;
          cmd_if.command          <= cur.command;
          cmd_if.servo_id         <= cur.servo_id;
          cmd_if.instruction      <= cur.instruction;
          cmd_if.param_count      <= cur.param_count;
          cmd_if.reply_data_count <= cur.reply_data_count;
          cmd_if.data_byte        <= cur.data_byte;
          tx_gap = pick_gap(tx_burst);
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and stalls the output at random.
  int rx_stall       = 0;
  int rx_burst       = 0;
  bit long_hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d, byte %0d", res_if.kind, res_if.out_byte);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("kind", exp_r.kind, res_if.kind);
          check_field("out_byte", exp_r.out_byte, res_if.out_byte);
          check_field("header_bad", exp_r.header_bad, res_if.header_bad);
          check_field("id_bad", exp_r.id_bad, res_if.id_bad);
          check_field("checksum_bad", exp_r.checksum_bad, res_if.checksum_bad);
          check_field("timed_out", exp_r.timed_out, res_if.timed_out);
          check_field("servo_error", exp_r.servo_error, res_if.servo_error);
          check_field("last", exp_r.last, res_if.last);
        end
        rx_stall = pick_gap(rx_burst);
      end
      // One long hold-off while the sender keeps going, so the block backs up.
      if (results_seen >= 60 && !long_hold_done) begin
        long_hold_done = 1'b1;
        rx_stall       = 150;
      end
      if (rx_stall != 0) begin
        rx_stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic add_item(cmd_e c, logic [ByteW-1:0] id, logic [ByteW-1:0] ins,
                          logic [CntW-1:0] pc, logic [CntW-1:0] rc, logic [ByteW-1:0] b);
    item_t it;
    it.command          = c;
    it.servo_id         = id;
    it.instruction      = ins;
    it.param_count      = pc;
    it.reply_data_count = rc;
    it.data_byte        = b;
    pending_items.push_back(it);
  endtask

  // Fields that the command does not use carry random noise.
  function automatic item_t noisy_item(cmd_e c, logic [ByteW-1:0] b);
    item_t it;
    it.command          = c;
    it.servo_id         = ByteW'($urandom);
    it.instruction      = ByteW'($urandom);
    it.param_count      = CntW'($urandom);
    it.reply_data_count = CntW'($urandom);
    it.data_byte        = b;
    return it;
  endfunction

  function automatic logic [CntW-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return CntW'($urandom_range(0, 4));
    if (r < 95) return CntW'($urandom_range(5, 32));
    return CntW'($urandom_range(33, 63));
  endfunction

  function automatic logic [ByteW-1:0] sync_or_bad();
    if ($urandom_range(0, 19) == 0) return ByteW'($urandom_range(0, 254));
    return SyncByte;
  endfunction

  // One request and its reply, sometimes corrupted or cut short.
  task automatic random_transaction(inout int count);
    item_t            seq[$];
    item_t            it;
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] len_b;
    logic [ByteW-1:0] err;
    logic [ByteW-1:0] id_sent;
    logic [ByteW-1:0] d;
    logic [ByteW-1:0] chk;
    int               pc_n;
    int               rc_n;
    int               cut;
    it                  = noisy_item(CmdStart, ByteW'($urandom));
    it.param_count      = pick_count();
    it.reply_data_count = pick_count();
    seq.push_back(it);
    pc_n = (it.param_count > MaxParams) ? MaxParams : it.param_count;
    rc_n = (it.reply_data_count > MaxReply) ? MaxReply : it.reply_data_count;
    for (int i = 0; i < pc_n; i++) seq.push_back(noisy_item(CmdParam, ByteW'($urandom)));
    seq.push_back(noisy_item(CmdReply, sync_or_bad()));
    seq.push_back(noisy_item(CmdReply, sync_or_bad()));
    id_sent = it.servo_id;
    if ($urandom_range(0, 9) == 0) id_sent = id_sent ^ ByteW'($urandom_range(1, 255));
    // The reply length is not checked by the block, so it may be anything.
    len_b = ($urandom_range(0, 9) == 0) ? ByteW'($urandom) : ByteW'(rc_n + 2);
    err   = ($urandom_range(0, 3) == 0) ? ByteW'($urandom) : '0;
    seq.push_back(noisy_item(CmdReply, id_sent));
    seq.push_back(noisy_item(CmdReply, len_b));
    seq.push_back(noisy_item(CmdReply, err));
    sum = id_sent + len_b + err;
    for (int i = 0; i < rc_n; i++) begin
      d   = ByteW'($urandom);
      sum = sum + d;
      seq.push_back(noisy_item(CmdReply, d));
    end
    chk = ~sum;
    if ($urandom_range(0, 9) == 0) chk = chk ^ ByteW'($urandom_range(1, 255));
    seq.push_back(noisy_item(CmdReply, chk));
    if ($urandom_range(0, 99) < 15) begin
      cut = $urandom_range(1, seq.size() - 1);
      while (seq.size() > cut) void'(seq.pop_back());
      if ($urandom_range(0, 2) != 0) seq.push_back(noisy_item(CmdTimeout, ByteW'($urandom)));
    end
    foreach (seq[i]) pending_items.push_back(seq[i]);
    count += seq.size();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 2))
        pending_items.push_back(noisy_item(cmd_e'($urandom_range(0, 3)), ByteW'($urandom)));
    end
  endtask

  initial begin
    int random_count;
    rst_ni = 1'b0;

    // Ignored while idle: timeout, parameter byte and reply byte.
    add_item(CmdTimeout, 8'h00, 8'h00, 6'd0, 6'd0, 8'h00);
    add_item(CmdParam, 8'h00, 8'h00, 6'd0, 6'd0, 8'h11);
    add_item(CmdReply, 8'h00, 8'h00, 6'd0, 6'd0, 8'hFF);
    // No parameters: checksum follows the header; then a clean, empty reply.
    add_item(CmdStart, 8'h00, 8'h00, 6'd0, 6'd0, 8'h00);
    add_item(CmdReply, 8'h00, 8'h00, 6'd0, 6'd0, 8'hFF);
    add_item(CmdReply, 8'h00, 8'h00, 6'd0, 6'd0, 8'hFF);
    add_item(CmdReply, 8'h00, 8'h00, 6'd0, 6'd0, 8'h00);
    add_item(CmdReply, 8'h00, 8'h00, 6'd0, 6'd0, 8'h02);
    add_item(CmdReply, 8'h00, 8'h00, 6'd0, 6'd0, 8'h00);
    add_item(CmdReply, 8'h00, 8'h00, 6'd0, 6'd0, 8'hFD);
    // Saturating counts, a stray reply byte, then a start while busy.
    add_item(CmdStart, 8'hFF, 8'hFF, 6'd63, 6'd63, 8'hFF);
    add_item(CmdParam, 8'h00, 8'h00, 6'd0, 6'd0, 8'hFF);
    add_item(CmdParam, 8'h00, 8'h00, 6'd0, 6'd0, 8'h00);
    add_item(CmdReply, 8'h00, 8'h00, 6'd0, 6'd0, 8'h42);
    add_item(CmdStart, 8'h01, 8'h03, 6'd1, 6'd1, 8'h00);
    add_item(CmdParam, 8'h00, 8'h00, 6'd0, 6'd0, 8'hAA);
    // Reply with a bad start byte, wrong id, an error byte and a bad checksum.
    add_item(CmdReply, 8'h00, 8'h00, 6'd0, 6'd0, 8'h00);
    add_item(CmdReply, 8'h00, 8'h00, 6'd0, 6'd0, 8'hFF);
    add_item(CmdReply, 8'h00, 8'h00, 6'd0, 6'd0, 8'h02);
    add_item(CmdReply, 8'h00, 8'h00, 6'd0, 6'd0, 8'h03);
    add_item(CmdReply, 8'h00, 8'h00, 6'd0, 6'd0, 8'h80);
    add_item(CmdReply, 8'h00, 8'h00, 6'd0, 6'd0, 8'h55);
    add_item(CmdReply, 8'h00, 8'h00, 6'd0, 6'd0, 8'h00);
    // Timeout while the reply is awaited.
    add_item(CmdStart, 8'h05, 8'h01, 6'd0, 6'd2, 8'h00);
    add_item(CmdTimeout, 8'h00, 8'h00, 6'd0, 6'd0, 8'h00);

    random_count = 0;
    while (random_count < 75) random_transaction(random_count);
    items_total = pending_items.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_accepted < items_total) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sbpt_pkg.sv
rtl/sbpt_if.sv
rtl/sbpt_core.sv
rtl/sbpt_serializer.sv
rtl/servo_bus_packet_transaction.sv
sim/tb_servo_bus_packet_transaction.sv
